// File: hw/rtl/wbci_pkg.sv
// Package for the wavelet band coefficient indexer: sizes, types and the microprogram.
`default_nettype none
package wbci_pkg;

  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned MAX_SCALES = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned SCL_W      = 4;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned BAND_W     = 3;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned NUM_W      = 24;
  localparam int unsigned PROD_W     = 2 * DIM_W;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned PC_W       = 5;

  localparam logic [KIND_W-1:0] KIND_MALLAT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUINCUNX  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INVERSE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNDEF     = 2'd3;

  localparam logic [BAND_W-1:0] BAND_HORIZ  = 3'd0;
  localparam logic [BAND_W-1:0] BAND_VERT   = 3'd1;
  localparam logic [BAND_W-1:0] BAND_DIAG   = 3'd2;
  localparam logic [BAND_W-1:0] BAND_SMOOTH = 3'd3;
  localparam logic [BAND_W-1:0] BAND_HALF   = 3'd4;
  localparam logic [BAND_W-1:0] BAND_RES    = 3'd5;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_SCALES = 2'd2;

  localparam logic [DIM_W-1:0] ROWS_RST   = 13'd256;
  localparam logic [DIM_W-1:0] COLS_RST   = 13'd256;
  localparam logic [SCL_W-1:0] SCALES_RST = 4'd4;

  localparam logic [CNT_W-1:0] DIV_STEPS_M1 = CNT_W'(NUM_W - 1);

  typedef enum logic [4:0] {
    OP_NOP,
    OP_HALVE_DEC,
    OP_FWD_OUT,
    OP_SET_ERR,
    OP_MUL_H,
    OP_MUL_V_LOAD,
    OP_MUL_D_ADD,
    OP_ADD,
    OP_NEXT_SCALE,
    OP_MUL_T,
    OP_DIV_T,
    OP_DIV_H,
    OP_SUB_MUL_V,
    OP_DIV_V,
    OP_DIV_D,
    OP_DIV_STEP,
    OP_DIV_OUT,
    OP_FINISH
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_KIND_BAD,
    C_KIND_INV,
    C_CNT_NZ,
    C_S_LAST,
    C_VAL_LT_ACC,
    C_VAL_LT_PROD,
    C_VAL_GE_PROD,
    C_DC_ZERO
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic kind_bad;
    logic kind_inv;
    logic cnt_nz;
    logic s_last;
    logic val_lt_acc;
    logic val_lt_prod;
    logic dc_zero;
  } stat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SCL_W-1:0]  scale;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [BAND_W-1:0] band;
    logic [NUM_W-1:0]  num;
  } req_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [SCL_W-1:0] scales;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [SCL_W-1:0]  scale;
    logic [BAND_W-1:0] band;
    logic              err;
  } res_t;

  localparam logic [PC_W-1:0] A_FWD    = 5'd2;
  localparam logic [PC_W-1:0] A_ERR    = 5'd4;
  localparam logic [PC_W-1:0] A_INV    = 5'd5;
  localparam logic [PC_W-1:0] A_SMOOTH = 5'd12;
  localparam logic [PC_W-1:0] A_DET    = 5'd15;
  localparam logic [PC_W-1:0] A_DIV    = 5'd20;
  localparam logic [PC_W-1:0] A_FIN    = 5'd22;
  localparam logic [PC_W-1:0] A_NONE   = 5'd0;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:  w = '{OP_NOP,        C_KIND_BAD,    A_ERR};
      5'd1:  w = '{OP_NOP,        C_KIND_INV,    A_INV};
      5'd2:  w = '{OP_HALVE_DEC,  C_CNT_NZ,      A_FWD};
      5'd3:  w = '{OP_FWD_OUT,    C_ALWAYS,      A_FIN};
      5'd4:  w = '{OP_SET_ERR,    C_ALWAYS,      A_FIN};
      5'd5:  w = '{OP_MUL_H,      C_NEVER,       A_NONE};
      5'd6:  w = '{OP_MUL_V_LOAD, C_NEVER,       A_NONE};
      5'd7:  w = '{OP_MUL_D_ADD,  C_NEVER,       A_NONE};
      5'd8:  w = '{OP_ADD,        C_NEVER,       A_NONE};
      5'd9:  w = '{OP_NOP,        C_S_LAST,      A_SMOOTH};
      5'd10: w = '{OP_MUL_H,      C_VAL_LT_ACC,  A_DET};
      5'd11: w = '{OP_NEXT_SCALE, C_ALWAYS,      A_INV};
      5'd12: w = '{OP_MUL_T,      C_NEVER,       A_NONE};
      5'd13: w = '{OP_NOP,        C_VAL_GE_PROD, A_ERR};
      5'd14: w = '{OP_DIV_T,      C_ALWAYS,      A_DIV};
      5'd15: w = '{OP_DIV_H,      C_VAL_LT_PROD, A_DIV};
      5'd16: w = '{OP_SUB_MUL_V,  C_NEVER,       A_NONE};
      5'd17: w = '{OP_DIV_V,      C_VAL_LT_PROD, A_DIV};
      5'd18: w = '{OP_SUB_MUL_V,  C_NEVER,       A_NONE};
      5'd19: w = '{OP_DIV_D,      C_DC_ZERO,     A_ERR};
      5'd20: w = '{OP_DIV_STEP,   C_CNT_NZ,      A_DIV};
      5'd21: w = '{OP_DIV_OUT,    C_ALWAYS,      A_FIN};
      5'd22: w = '{OP_FINISH,     C_NEVER,       A_NONE};
      default: w = '{OP_FINISH,   C_NEVER,       A_NONE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/wbci_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none
module wbci_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            stall_i,
  input  wire wbci_pkg::stat_t stat_i,
  output wbci_pkg::op_e        op_o,
  output logic                 busy_o
);
  import wbci_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  logic            busy_q, busy_d;
  ucode_t          word;
  logic            take;
  logic            hold;

  always_comb begin
    word = ucode(pc_q);
    case (word.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_KIND_BAD:    take = stat_i.kind_bad;
      C_KIND_INV:    take = stat_i.kind_inv;
      C_CNT_NZ:      take = stat_i.cnt_nz;
      C_S_LAST:      take = stat_i.s_last;
      C_VAL_LT_ACC:  take = stat_i.val_lt_acc;
      C_VAL_LT_PROD: take = stat_i.val_lt_prod;
      C_VAL_GE_PROD: take = !stat_i.val_lt_prod;
      C_DC_ZERO:     take = stat_i.dc_zero;
      default:       take = 1'b0;
    endcase
    // result slot still occupied: wait on the finish step
    hold = (word.op == OP_FINISH) && stall_i;
    op_o = (busy_q && !hold) ? word.op : OP_NOP;
    pc_d   = pc_q;
    busy_d = busy_q;
    if (start_i) begin
      pc_d   = '0;
      busy_d = 1'b1;
    end else if (busy_q && !hold) begin
      pc_d = take ? word.target : pc_q + PC_W'(1);
      if (word.op == OP_FINISH) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule
`default_nettype wire

// File: hw/rtl/wbci_dpath.sv
// Datapath: size registers, shared multiplier, accumulator and radix-2 divider.
`default_nettype none
module wbci_dpath (
  input  wire logic            clk_i,
  input  wire logic            start_i,
  input  wire wbci_pkg::req_t  req_i,
  input  wire wbci_pkg::cfg_t  cfg_i,
  input  wire wbci_pkg::op_e   op_i,
  output wbci_pkg::stat_t      stat_o,
  output wbci_pkg::res_t       res_o
);
  import wbci_pkg::*;

  function automatic logic [DIM_W-1:0] half_up(input logic [DIM_W-1:0] v);
    return {1'b0, v[DIM_W-1:1]} + {{(DIM_W-1){1'b0}}, v[0]};
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  logic [KIND_W-1:0] kind_q;
  logic [POS_W-1:0]  row_q, col_q;
  logic [BAND_W-1:0] band_q;
  logic [DIM_W-1:0]  nl_q, nc_q;
  logic [NUM_W-1:0]  val_q;
  logic [SCL_W-1:0]  s_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] prod_q, acc_q;
  logic [DIM_W-1:0]  div_q, rem_q;
  logic [NUM_W-1:0]  quo_q;
  res_t              wrk_q;

  logic [DIM_W-1:0]  hl, hc, vl, vc;
  logic [DIM_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_d;
  logic [SCL_W-1:0]  eff_sc, last_sc;
  logic [DIM_W:0]    sh, trial;
  logic              ge;
  logic [NUM_W-1:0]  val_sub_acc, val_sub_prod;
  res_t              fwd;

  always_comb begin
    hl = half_up(nl_q);
    hc = {1'b0, nc_q[DIM_W-1:1]};
    vl = {1'b0, nl_q[DIM_W-1:1]};
    vc = half_up(nc_q);
    case (op_i)
      OP_MUL_H:                   begin mul_a = hl;   mul_b = hc;   end
      OP_MUL_V_LOAD, OP_SUB_MUL_V: begin mul_a = vl;   mul_b = vc;   end
      OP_MUL_D_ADD:               begin mul_a = vl;   mul_b = hc;   end
      OP_MUL_T:                   begin mul_a = nl_q; mul_b = nc_q; end
      default:                    begin mul_a = nl_q; mul_b = nc_q; end
    endcase
    prod_d = mul_a * mul_b;

    if (cfg_i.scales < SCL_W'(2)) eff_sc = SCL_W'(2);
    else if (cfg_i.scales > SCL_W'(MAX_SCALES)) eff_sc = SCL_W'(MAX_SCALES);
    else eff_sc = cfg_i.scales;
    last_sc = eff_sc - SCL_W'(1);

    sh    = {rem_q, quo_q[NUM_W-1]};
    ge    = sh >= {1'b0, div_q};
    trial = sh - {1'b0, div_q};

    val_sub_acc  = NUM_W'(PROD_W'(val_q) - acc_q);
    val_sub_prod = NUM_W'(PROD_W'(val_q) - prod_q);

    fwd = '0;
    if (kind_q == KIND_MALLAT) begin
      case (band_q)
        BAND_HORIZ:  begin fwd.row = row_q;               fwd.col = col_q + nc_q[POS_W-1:0]; end
        BAND_VERT:   begin fwd.row = row_q + nl_q[POS_W-1:0]; fwd.col = col_q;           end
        BAND_DIAG:   begin
          fwd.row = row_q + nl_q[POS_W-1:0];
          fwd.col = col_q + nc_q[POS_W-1:0];
        end
        BAND_SMOOTH: begin fwd.row = row_q;               fwd.col = col_q;               end
        default:     fwd.err = 1'b1;
      endcase
    end else begin
      case (band_q)
        BAND_SMOOTH: begin fwd.row = row_q;               fwd.col = col_q;               end
        BAND_HALF:   begin fwd.row = row_q;               fwd.col = col_q + nc_q[POS_W-1:0]; end
        BAND_RES:    begin fwd.row = row_q + nl_q[POS_W-1:0]; fwd.col = col_q;           end
        default:     fwd.err = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      kind_q <= req_i.kind;
      row_q  <= req_i.row;
      col_q  <= req_i.col;
      band_q <= req_i.band;
      val_q  <= req_i.num;
      cnt_q  <= CNT_W'(req_i.scale);
      nl_q   <= clamp_dim(cfg_i.rows);
      nc_q   <= clamp_dim(cfg_i.cols);
      s_q    <= '0;
    end else begin
      case (op_i)
        OP_HALVE_DEC: begin
          nl_q  <= half_up(nl_q);
          nc_q  <= half_up(nc_q);
          cnt_q <= cnt_q - CNT_W'(1);
        end
        OP_FWD_OUT: wrk_q <= fwd;
        OP_SET_ERR: wrk_q <= '{row: '0, col: '0, scale: '0, band: '0, err: 1'b1};
        OP_MUL_H, OP_MUL_T: prod_q <= prod_d;
        OP_MUL_V_LOAD: begin
          acc_q  <= prod_q;
          prod_q <= prod_d;
        end
        OP_MUL_D_ADD: begin
          acc_q  <= acc_q + prod_q;
          prod_q <= prod_d;
        end
        OP_ADD: acc_q <= acc_q + prod_q;
        OP_NEXT_SCALE: begin
          val_q <= val_sub_acc;
          s_q   <= s_q + SCL_W'(1);
          nl_q  <= half_up(nl_q);
          nc_q  <= half_up(nc_q);
        end
        OP_SUB_MUL_V: begin
          val_q  <= val_sub_prod;
          prod_q <= prod_d;
        end
        OP_DIV_T, OP_DIV_H, OP_DIV_V, OP_DIV_D: begin
          rem_q <= '0;
          quo_q <= val_q;
          cnt_q <= DIV_STEPS_M1;
          wrk_q.err <= 1'b0;
          case (op_i)
            OP_DIV_T: begin
              div_q       <= nc_q;
              wrk_q.band  <= BAND_SMOOTH;
              wrk_q.scale <= last_sc - SCL_W'(1);
            end
            OP_DIV_H: begin
              div_q       <= hc;
              wrk_q.band  <= BAND_HORIZ;
              wrk_q.scale <= s_q;
            end
            OP_DIV_V: begin
              div_q       <= vc;
              wrk_q.band  <= BAND_VERT;
              wrk_q.scale <= s_q;
            end
            default: begin
              div_q       <= hc;
              wrk_q.band  <= BAND_DIAG;
              wrk_q.scale <= s_q;
            end
          endcase
        end
        OP_DIV_STEP: begin
          rem_q <= ge ? trial[DIM_W-1:0] : sh[DIM_W-1:0];
          quo_q <= {quo_q[NUM_W-2:0], ge};
          cnt_q <= cnt_q - CNT_W'(1);
        end
        OP_DIV_OUT: begin
          wrk_q.row <= quo_q[POS_W-1:0];
          wrk_q.col <= rem_q[POS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat_o.kind_bad    = kind_q == KIND_UNDEF;
    stat_o.kind_inv    = kind_q == KIND_INVERSE;
    stat_o.cnt_nz      = cnt_q != '0;
    stat_o.s_last      = s_q >= last_sc;
    stat_o.val_lt_acc  = PROD_W'(val_q) < acc_q;
    stat_o.val_lt_prod = PROD_W'(val_q) < prod_q;
    stat_o.dc_zero     = hc == '0;
  end

  assign res_o = wrk_q;

endmodule
`default_nettype wire

// File: hw/rtl/wavelet_band_coefficient_indexer_top.sv
// Top level of the wavelet band coefficient indexer: register port, handshakes, result register.
//
// Input channel (in_valid_i/in_ready_o) takes one request: kind, scale, row_in, col_in,
// band_in and coef_number. Output channel (out_valid_o/out_ready_i) returns one result
// per request: row_out, col_out, scale_out, band_out and error.
// A microprogram runs one request at a time; in_ready_o is high while it is not running.
// Path from input transfer to result valid, by kind:
//   unknown kind: straight to the error result; forward operations: a loop of halving
//   steps over the scale; inverse: a loop over each scale stepped over, then the final
//   level, worked out with the shared 13x13 multiplier and the 24-step radix-2 divider.
// The result register decouples the sides: a new request is taken while a result waits,
// and the microprogram stalls on its finish step only when the result register is full.
// Reset clears the sequencer and output valid and sets image_rows = 256,
// image_cols = 256, scale_count = 4. Registers at byte addresses 0, 4, 8 over APB;
// pready is always high and writes belong only while the block is idle.
`default_nettype none
module wavelet_band_coefficient_indexer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [wbci_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [wbci_pkg::SCL_W-1:0]    scale_i,
  input  wire logic [wbci_pkg::POS_W-1:0]    row_in_i,
  input  wire logic [wbci_pkg::POS_W-1:0]    col_in_i,
  input  wire logic [wbci_pkg::BAND_W-1:0]   band_in_i,
  input  wire logic [wbci_pkg::NUM_W-1:0]    coef_number_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [wbci_pkg::POS_W-1:0]    row_out_o,
  output logic      [wbci_pkg::POS_W-1:0]    col_out_o,
  output logic      [wbci_pkg::SCL_W-1:0]    scale_out_o,
  output logic      [wbci_pkg::BAND_W-1:0]   band_out_o,
  output logic                               error_o
);
  import wbci_pkg::*;

  cfg_t  cfg_q;
  req_t  req;
  stat_t stat;
  op_e   op;
  res_t  wrk;
  res_t  out_q;
  logic  out_valid_q;
  logic  busy;
  logic  start;
  logic  stall;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows   <= ROWS_RST;
      cfg_q.cols   <= COLS_RST;
      cfg_q.scales <= SCALES_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROWS:   cfg_q.rows   <= pwdata[DIM_W-1:0];
        REG_COLS:   cfg_q.cols   <= pwdata[DIM_W-1:0];
        REG_SCALES: cfg_q.scales <= pwdata[SCL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS:   prdata = {{(32-DIM_W){1'b0}}, cfg_q.rows};
      REG_COLS:   prdata = {{(32-DIM_W){1'b0}}, cfg_q.cols};
      REG_SCALES: prdata = {{(32-SCL_W){1'b0}}, cfg_q.scales};
      default:    prdata = '0;
    endcase
  end

  assign in_ready_o = !busy;
  assign start      = in_valid_i && !busy;
  assign stall      = out_valid_q && !out_ready_i;

  always_comb begin
    req.kind  = kind_i;
    req.scale = scale_i;
    req.row   = row_in_i;
    req.col   = col_in_i;
    req.band  = band_in_i;
    req.num   = coef_number_i;
  end

  wbci_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stall_i (stall),
    .stat_i  (stat),
    .op_o    (op),
    .busy_o  (busy)
  );

  wbci_dpath u_dpath (
    .clk_i   (clk_i),
    .start_i (start),
    .req_i   (req),
    .cfg_i   (cfg_q),
    .op_i    (op),
    .stat_o  (stat),
    .res_o   (wrk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op == OP_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_FINISH) begin
      out_q <= wrk;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_out_o   = out_q.row;
  assign col_out_o   = out_q.col;
  assign scale_out_o = out_q.scale;
  assign band_out_o  = out_q.band;
  assign error_o     = out_q.err;

endmodule
`default_nettype wire
